FILE: src/beacon_hop_and_bpsk_sequencer_macros.svh
// Assertion helpers used by the checker file.
`ifndef BEACON_HOP_AND_BPSK_SEQUENCER_MACROS_SVH
`define BEACON_HOP_AND_BPSK_SEQUENCER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset
`define BHBS_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset
`define BHBS_ASSERT_NXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/bhbs_pkg.sv
`default_nettype none

package bhbs_pkg;

   // Fixed field widths
   localparam int FREQ_W    = 32;
   localparam int PHASE_W   = 5;
   localparam int BYTE_W    = 8;
   localparam int BIT_W     = 3;
   localparam int CMD_W     = 3;
   localparam int FUNC_W    = 3;
   localparam int SLOT_W    = 6;
   localparam int CSR_IDX_W = 3;
   localparam int HOP_CNT_W = 5;
   localparam int MSG_LEN_W = 7;

   localparam logic [PHASE_W-1:0] PHASE_ONE = 5'd15;
   localparam logic [BIT_W-1:0]   BIT_LAST  = 3'd7;

   // Input transaction function codes
   typedef enum logic [FUNC_W-1:0] {
      FUNC_HOP_TRIG = 3'd0,
      FUNC_PSK_TRIG = 3'd1,
      FUNC_HOP_CLK  = 3'd2,
      FUNC_PSK_CLK  = 3'd3,
      FUNC_LOAD_SYM = 3'd4,
      FUNC_LOAD_MSG = 3'd5
   } func_type;

   // Synthesizer commands
   typedef enum logic [CMD_W-1:0] {
      CMD_NONE  = 3'd0,
      CMD_UP    = 3'd1,
      CMD_FREQ  = 3'd2,
      CMD_PHASE = 3'd3,
      CMD_DOWN  = 3'd4
   } cmd_type;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE_FREQ      = 3'd0,
      CSR_FREQ_OFFSET    = 3'd1,
      CSR_HOP_SPACING    = 3'd2,
      CSR_HOP_COUNT      = 3'd3,
      CSR_MESSAGE_LENGTH = 3'd4
   } csr_type;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_HOP,
      MODE_PSK
   } mode_type;

   // Position inside a burst
   typedef enum logic [2:0] {
      STEP_TONE,
      STEP_CARRIER,
      STEP_PREAMBLE,
      STEP_BITS,
      STEP_ZERO,
      STEP_DOWN,
      STEP_RELEASE
   } step_type;

   // Source of the frequency word
   typedef enum logic [1:0] {
      FSEL_ZERO,
      FSEL_BASE,
      FSEL_HOP
   } fsel_type;

   // Decoded transaction handed from the sequencer to the datapath
   typedef struct packed {
      cmd_type          cmd;
      fsel_type         fsel;
      logic [BIT_W-1:0] bit_sel;
      logic             hop_req;
      logic             psk_req;
   } ctrl_type;

endpackage

`default_nettype wire

FILE: src/bhbs_tables.sv
`default_nettype none

module bhbs_tables #(
   parameter int MAX_HOPS    = 16,
   parameter int MAX_MESSAGE = 64,
   parameter int STEP_W      = 7
) (
   input  wire logic                         clock,
   input  wire logic                         en,
   input  wire logic [bhbs_pkg::FUNC_W-1:0]  func,
   input  wire logic [bhbs_pkg::SLOT_W-1:0]  slot,
   input  wire logic [bhbs_pkg::BYTE_W-1:0]  load_value,
   input  wire logic                         hop_re,
   input  wire logic                         msg_re,
   input  wire logic [STEP_W-1:0]            rd_addr,
   output logic      [bhbs_pkg::BYTE_W-1:0]  hop_rd,
   output logic      [bhbs_pkg::BYTE_W-1:0]  msg_rd
);
   import bhbs_pkg::*;

   localparam int HOP_AW = (MAX_HOPS > 1) ? $clog2(MAX_HOPS) : 1;
   localparam int MSG_AW = (MAX_MESSAGE > 1) ? $clog2(MAX_MESSAGE) : 1;

   logic [BYTE_W-1:0] hop_mem [MAX_HOPS];
   logic [BYTE_W-1:0] msg_mem [MAX_MESSAGE];
   logic [BYTE_W-1:0] hop_rd_ff;
   logic [BYTE_W-1:0] msg_rd_ff;
   logic              hop_we;
   logic              msg_we;
   logic [HOP_AW-1:0] hop_waddr;
   logic [MSG_AW-1:0] msg_waddr;

   // Loads beyond the table depth are dropped
   assign hop_we    = en && (func == FUNC_LOAD_SYM) && (int'(slot) < MAX_HOPS);
   assign msg_we    = en && (func == FUNC_LOAD_MSG) && (int'(slot) < MAX_MESSAGE);
   assign hop_waddr = HOP_AW'(slot);
   assign msg_waddr = MSG_AW'(slot);

   // One transaction per cycle either writes or reads, never both; a read
   // in the cycle after a write to the same entry already sees the new byte.
   always_ff @(posedge clock) begin
      if (hop_we) begin
         hop_mem[hop_waddr] <= load_value;
      end
      if (hop_re) begin
         hop_rd_ff <= hop_mem[rd_addr[HOP_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (msg_we) begin
         msg_mem[msg_waddr] <= load_value;
      end
      if (msg_re) begin
         msg_rd_ff <= msg_mem[rd_addr[MSG_AW-1:0]];
      end
   end

   // Read data holds until the next read
   assign hop_rd = hop_rd_ff;
   assign msg_rd = msg_rd_ff;

endmodule

`default_nettype wire

FILE: src/bhbs_ctrl.sv
`default_nettype none

module bhbs_ctrl #(
   parameter int MAX_HOPS        = 16,
   parameter int MAX_MESSAGE     = 64,
   parameter int PREAMBLE_CLOCKS = 8,
   parameter int STEP_W          = 7
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           en,
   input  wire logic [bhbs_pkg::FUNC_W-1:0]    func,
   input  wire logic [bhbs_pkg::HOP_CNT_W-1:0] hop_count,
   input  wire logic [bhbs_pkg::MSG_LEN_W-1:0] message_length,
   output bhbs_pkg::ctrl_type                  ctrl,
   output logic                                hop_re,
   output logic                                msg_re,
   output logic      [STEP_W-1:0]              rd_addr
);
   import bhbs_pkg::*;

   localparam int LEN_W = STEP_W + 8;

   mode_type         mode_ff, mode_in;
   step_type         step_ff, step_in;
   logic [STEP_W-1:0] idx_ff, idx_in;
   logic [BIT_W-1:0] bit_ff, bit_in;
   logic [LEN_W-1:0] hop_len;
   logic [LEN_W-1:0] msg_len;
   logic [LEN_W-1:0] idx_next;
   logic             tone_done;
   logic             pre_done;
   logic             msg_done;

   // Clamp the burst lengths to 1..depth
   always_comb begin
      if (hop_count == '0) begin
         hop_len = LEN_W'(1);
      end else if (LEN_W'(hop_count) > LEN_W'(MAX_HOPS)) begin
         hop_len = LEN_W'(MAX_HOPS);
      end else begin
         hop_len = LEN_W'(hop_count);
      end
      if (message_length == '0) begin
         msg_len = LEN_W'(1);
      end else if (LEN_W'(message_length) > LEN_W'(MAX_MESSAGE)) begin
         msg_len = LEN_W'(MAX_MESSAGE);
      end else begin
         msg_len = LEN_W'(message_length);
      end
   end

   assign idx_next  = LEN_W'(idx_ff) + LEN_W'(1);
   assign tone_done = idx_next >= hop_len;
   assign pre_done  = idx_next >= LEN_W'(PREAMBLE_CLOCKS - 1);
   assign msg_done  = idx_next >= msg_len;
   assign rd_addr   = idx_ff;

   // Sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         step_ff <= STEP_TONE;
         idx_ff  <= '0;
         bit_ff  <= '0;
      end else if (en) begin
         mode_ff <= mode_in;
         step_ff <= step_in;
         idx_ff  <= idx_in;
         bit_ff  <= bit_in;
      end
   end

   // Next state and decoded command for the accepted transaction
   always_comb begin
      mode_in      = mode_ff;
      step_in      = step_ff;
      idx_in       = idx_ff;
      bit_in       = bit_ff;
      ctrl.cmd     = CMD_NONE;
      ctrl.fsel    = FSEL_ZERO;
      ctrl.bit_sel = bit_ff;
      hop_re       = 1'b0;
      msg_re       = 1'b0;

      unique case (func)
         FUNC_HOP_TRIG, FUNC_PSK_TRIG: begin
            if (mode_ff == MODE_IDLE) begin
               mode_in  = (func == FUNC_HOP_TRIG) ? MODE_HOP : MODE_PSK;
               step_in  = (func == FUNC_HOP_TRIG) ? STEP_TONE : STEP_CARRIER;
               idx_in   = '0;
               bit_in   = '0;
               ctrl.cmd = CMD_UP;
            end
         end
         FUNC_HOP_CLK, FUNC_PSK_CLK: begin
            if (((func == FUNC_HOP_CLK) && (mode_ff == MODE_HOP)) ||
                ((func == FUNC_PSK_CLK) && (mode_ff == MODE_PSK))) begin
               unique case (step_ff)
                  STEP_TONE: begin
                     ctrl.cmd  = CMD_FREQ;
                     ctrl.fsel = FSEL_HOP;
                     hop_re    = en;
                     if (tone_done) begin
                        idx_in  = '0;
                        step_in = STEP_ZERO;
                     end else begin
                        idx_in = idx_next[STEP_W-1:0];
                     end
                  end
                  STEP_CARRIER: begin
                     ctrl.cmd  = CMD_FREQ;
                     ctrl.fsel = FSEL_BASE;
                     idx_in    = '0;
                     step_in   = (PREAMBLE_CLOCKS > 1) ? STEP_PREAMBLE : STEP_BITS;
                  end
                  STEP_PREAMBLE: begin
                     if (pre_done) begin
                        idx_in  = '0;
                        bit_in  = '0;
                        step_in = STEP_BITS;
                     end else begin
                        idx_in = idx_next[STEP_W-1:0];
                     end
                  end
                  STEP_BITS: begin
                     ctrl.cmd = CMD_PHASE;
                     msg_re   = en;
                     if (bit_ff == BIT_LAST) begin
                        bit_in = '0;
                        if (msg_done) begin
                           idx_in  = '0;
                           step_in = STEP_ZERO;
                        end else begin
                           idx_in = idx_next[STEP_W-1:0];
                        end
                     end else begin
                        bit_in = bit_ff + BIT_W'(1);
                     end
                  end
                  STEP_ZERO: begin
                     ctrl.cmd = CMD_FREQ;
                     step_in  = STEP_DOWN;
                  end
                  STEP_DOWN: begin
                     ctrl.cmd = CMD_DOWN;
                     step_in  = STEP_RELEASE;
                  end
                  default: begin
                     // release: back to idle, outputs drop
                     mode_in = MODE_IDLE;
                     step_in = STEP_TONE;
                     idx_in  = '0;
                     bit_in  = '0;
                  end
               endcase
            end
         end
         default: begin
            // loads and unused codes leave the sequencer alone
         end
      endcase

      ctrl.hop_req = (mode_in == MODE_HOP);
      ctrl.psk_req = (mode_in == MODE_PSK);
   end

endmodule

`default_nettype wire

FILE: src/bhbs_pipe.sv
`default_nettype none

module bhbs_pipe (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          en,
   input  wire bhbs_pkg::ctrl_type            ctrl,
   input  wire logic [bhbs_pkg::BYTE_W-1:0]   hop_rd,
   input  wire logic [bhbs_pkg::BYTE_W-1:0]   msg_rd,
   input  wire logic [bhbs_pkg::FREQ_W-1:0]   base_freq,
   input  wire logic [bhbs_pkg::FREQ_W-1:0]   base_off,
   input  wire logic [bhbs_pkg::FREQ_W-1:0]   hop_spacing,
   output logic                               s1_free,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [bhbs_pkg::CMD_W-1:0]    rsp_command,
   output logic      [bhbs_pkg::FREQ_W-1:0]   rsp_freq_word,
   output logic      [bhbs_pkg::PHASE_W-1:0]  rsp_phase_word,
   output logic                               rsp_hop_request,
   output logic                               rsp_psk_request,
   output logic                               rsp_rf_enable
);
   import bhbs_pkg::*;

   logic                s1_valid_ff, s1_valid_in;
   ctrl_type            s1_ctrl_ff, s1_ctrl_in;
   logic                out_valid_ff, out_valid_in;
   logic [CMD_W-1:0]    cmd_ff;
   logic [FREQ_W-1:0]   freq_ff;
   logic [PHASE_W-1:0]  phase_ff;
   logic                hop_ff;
   logic                psk_ff;
   logic                rf_ff;
   logic                out_free;
   logic                s1_move;
   logic [FREQ_W-1:0]   hop_prod;
   logic [FREQ_W-1:0]   freq_val;
   logic [PHASE_W-1:0]  phase_val;

   // Handshake between the read stage and the output register
   assign out_free = !out_valid_ff || rsp_ready;
   assign s1_move  = s1_valid_ff && out_free;
   assign s1_free  = !s1_valid_ff || out_free;

   always_comb begin
      s1_ctrl_in = en ? ctrl : s1_ctrl_ff;
      if (en) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (s1_move) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ctrl_ff <= s1_ctrl_in;
   end

   // Hop word: base + offset + symbol * spacing, mod 2^32
   assign hop_prod = {{(FREQ_W-BYTE_W){1'b0}}, hop_rd} * hop_spacing;

   always_comb begin
      unique case (s1_ctrl_ff.fsel)
         FSEL_BASE: freq_val = base_freq;
         FSEL_HOP:  freq_val = base_off + hop_prod;
         default:   freq_val = '0;
      endcase
      if ((s1_ctrl_ff.cmd == CMD_PHASE) && msg_rd[s1_ctrl_ff.bit_sel]) begin
         phase_val = PHASE_ONE;
      end else begin
         phase_val = '0;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (s1_move) begin
         cmd_ff   <= s1_ctrl_ff.cmd;
         freq_ff  <= freq_val;
         phase_ff <= phase_val;
         hop_ff   <= s1_ctrl_ff.hop_req;
         psk_ff   <= s1_ctrl_ff.psk_req;
         rf_ff    <= s1_ctrl_ff.hop_req || s1_ctrl_ff.psk_req;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_command     = cmd_ff;
   assign rsp_freq_word   = freq_ff;
   assign rsp_phase_word  = phase_ff;
   assign rsp_hop_request = hop_ff;
   assign rsp_psk_request = psk_ff;
   assign rsp_rf_enable   = rf_ff;

endmodule

`default_nettype wire

FILE: src/beacon_hop_and_bpsk_sequencer.sv
// Beacon sequencer: turns trigger, clock and load transactions into
// synthesizer commands, one response per request.
// req_*: func selects hop/PSK trigger, hop/PSK clock, or a load of the hop
//   symbol table or message buffer (slot, load_value).
// rsp_*: command, frequency word, phase word and the request levels that
//   hold after the transaction.
// csr_*: register writes (base, offset, step, hop count, message length),
//   always ready; write only while no transaction is in flight.
// Throughput: one transaction per cycle while rsp_ready stays high. Each
//   accepted request passes the read stage (synchronous table read), then
//   the output register, which takes the multiply-add of the hop word and raises rsp_valid.
// Reset: sequencer idle, registers to their defaults; the symbol and message
//   tables are not cleared and must be loaded before use.
// Stall: while rsp_ready is low the response holds; one more request is
//   taken into the read stage, then req_ready drops until the output frees.
`default_nettype none

module beacon_hop_and_bpsk_sequencer #(
   parameter int MAX_HOPS        = 16,
   parameter int MAX_MESSAGE     = 64,
   parameter int PREAMBLE_CLOCKS = 8
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [bhbs_pkg::FUNC_W-1:0]     req_func,
   input  wire logic [bhbs_pkg::SLOT_W-1:0]     req_slot,
   input  wire logic [bhbs_pkg::BYTE_W-1:0]     req_load_value,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic      [bhbs_pkg::CMD_W-1:0]      rsp_command,
   output logic      [bhbs_pkg::FREQ_W-1:0]     rsp_freq_word,
   output logic      [bhbs_pkg::PHASE_W-1:0]    rsp_phase_word,
   output logic                                 rsp_hop_request,
   output logic                                 rsp_psk_request,
   output logic                                 rsp_rf_enable,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [bhbs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [bhbs_pkg::FREQ_W-1:0]     csr_data
);
   import bhbs_pkg::*;

   localparam int STEP_MAX_A = (MAX_HOPS > MAX_MESSAGE) ? MAX_HOPS : MAX_MESSAGE;
   localparam int STEP_MAX   = (STEP_MAX_A > PREAMBLE_CLOCKS) ? STEP_MAX_A : PREAMBLE_CLOCKS;
   localparam int STEP_W     = $clog2(STEP_MAX + 1);

   logic [FREQ_W-1:0]    base_freq_ff;
   logic [FREQ_W-1:0]    freq_offset_ff;
   logic [FREQ_W-1:0]    hop_spacing_ff;
   logic [HOP_CNT_W-1:0] hop_count_ff;
   logic [MSG_LEN_W-1:0] message_length_ff;
   logic [FREQ_W-1:0]    base_off_ff, base_off_in;
   logic                 accept;
   logic                 csr_we;
   ctrl_type             ctrl;
   logic                 hop_re;
   logic                 msg_re;
   logic [STEP_W-1:0]    rd_addr;
   logic [BYTE_W-1:0]    hop_rd;
   logic [BYTE_W-1:0]    msg_rd;
   logic                 s1_free;

   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;
   assign req_ready = s1_free;
   assign accept    = req_valid && req_ready;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_freq_ff      <= '0;
         freq_offset_ff    <= '0;
         hop_spacing_ff    <= '0;
         hop_count_ff      <= HOP_CNT_W'(1);
         message_length_ff <= MSG_LEN_W'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BASE_FREQ:      base_freq_ff      <= csr_data;
            CSR_FREQ_OFFSET:    freq_offset_ff    <= csr_data;
            CSR_HOP_SPACING:    hop_spacing_ff    <= csr_data;
            CSR_HOP_COUNT:      hop_count_ff      <= csr_data[HOP_CNT_W-1:0];
            CSR_MESSAGE_LENGTH: message_length_ff <= csr_data[MSG_LEN_W-1:0];
            default: begin
               // unmapped index, write dropped
            end
         endcase
      end
   end

   // Base plus offset, settled long before any hop clock uses it
   assign base_off_in = base_freq_ff + freq_offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_off_ff <= '0;
      end else begin
         base_off_ff <= base_off_in;
      end
   end

   bhbs_ctrl #(
      .MAX_HOPS        (MAX_HOPS),
      .MAX_MESSAGE     (MAX_MESSAGE),
      .PREAMBLE_CLOCKS (PREAMBLE_CLOCKS),
      .STEP_W          (STEP_W)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .en             (accept),
      .func           (req_func),
      .hop_count      (hop_count_ff),
      .message_length (message_length_ff),
      .ctrl           (ctrl),
      .hop_re         (hop_re),
      .msg_re         (msg_re),
      .rd_addr        (rd_addr)
   );

   bhbs_tables #(
      .MAX_HOPS    (MAX_HOPS),
      .MAX_MESSAGE (MAX_MESSAGE),
      .STEP_W      (STEP_W)
   ) u_tables (
      .clock      (clock),
      .en         (accept),
      .func       (req_func),
      .slot       (req_slot),
      .load_value (req_load_value),
      .hop_re     (hop_re),
      .msg_re     (msg_re),
      .rd_addr    (rd_addr),
      .hop_rd     (hop_rd),
      .msg_rd     (msg_rd)
   );

   bhbs_pipe u_pipe (
      .clock           (clock),
      .reset           (reset),
      .en              (accept),
      .ctrl            (ctrl),
      .hop_rd          (hop_rd),
      .msg_rd          (msg_rd),
      .base_freq       (base_freq_ff),
      .base_off        (base_off_ff),
      .hop_spacing     (hop_spacing_ff),
      .s1_free         (s1_free),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_command     (rsp_command),
      .rsp_freq_word   (rsp_freq_word),
      .rsp_phase_word  (rsp_phase_word),
      .rsp_hop_request (rsp_hop_request),
      .rsp_psk_request (rsp_psk_request),
      .rsp_rf_enable   (rsp_rf_enable)
   );

endmodule

`default_nettype wire

FILE: src/bhbs_checker.sv
`default_nettype none
`include "beacon_hop_and_bpsk_sequencer_macros.svh"

module bhbs_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic [bhbs_pkg::CMD_W-1:0]     rsp_command,
   input wire logic [bhbs_pkg::FREQ_W-1:0]    rsp_freq_word,
   input wire logic [bhbs_pkg::PHASE_W-1:0]   rsp_phase_word,
   input wire logic                           rsp_hop_request,
   input wire logic                           rsp_psk_request,
   input wire logic                           rsp_rf_enable
);
   import bhbs_pkg::*;

   // RF follows the two request levels, which never overlap
   `BHBS_ASSERT_IMP(a_rf_level, rsp_valid, (rsp_rf_enable == (rsp_hop_request || rsp_psk_request)) && !(rsp_hop_request && rsp_psk_request), "rf_enable does not match request levels")

   // Frequency word only on set frequency
   `BHBS_ASSERT_IMP(a_freq_zero, rsp_valid && (rsp_command != CMD_FREQ), rsp_freq_word == '0, "freq_word nonzero outside set frequency")

   // Phase commands come only inside a PSK burst and carry 0 or 15
   `BHBS_ASSERT_IMP(a_phase_psk, rsp_valid && (rsp_command == CMD_PHASE), rsp_psk_request && ((rsp_phase_word == '0) || (rsp_phase_word == PHASE_ONE)), "bad phase transaction")

   // No phase word outside set phase
   `BHBS_ASSERT_IMP(a_phase_zero, rsp_valid && (rsp_command != CMD_PHASE), rsp_phase_word == '0, "phase_word nonzero outside set phase")

   // A stalled response holds
   `BHBS_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_command) && $stable(rsp_freq_word), "response changed while stalled")

endmodule

bind beacon_hop_and_bpsk_sequencer bhbs_checker u_checker (.*);

`default_nettype wire

FILE: verif/beacon_hop_and_bpsk_sequencer_test.sv
`timescale 1ns / 100ps

module beacon_hop_and_bpsk_sequencer_test;
   import bhbs_pkg::*;

   localparam int MAX_HOPS        = 16;
   localparam int MAX_MESSAGE     = 64;
   localparam int PREAMBLE_CLOCKS = 8;
   localparam int CYCLE_LIMIT     = 600000;
   localparam int RANDOM_WORK     = 1150;

   // codes outside the defined sets; the block must ignore them
   localparam logic [FUNC_W-1:0]    FUNC_UNUSED = 3'd7;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE   = 3'd7;

   // burst positions tracked by the predictor
   localparam int unsigned HOP_TONE     = 0;
   localparam int unsigned HOP_ZERO     = 1;
   localparam int unsigned PSK_CARRIER  = 0;
   localparam int unsigned PSK_PREAMBLE = 1;
   localparam int unsigned PSK_BITS     = 2;
   localparam int unsigned PSK_ZERO     = 3;

   typedef struct {
      cmd_type            command;
      logic [FREQ_W-1:0]  freq_word;
      logic [PHASE_W-1:0] phase_word;
      logic               hop_req;
      logic               psk_req;
      logic               rf_en;
   } synth_cmd_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [FUNC_W-1:0]    req_func = '0;
   logic [SLOT_W-1:0]    req_slot = '0;
   logic [BYTE_W-1:0]    req_load_value = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b1;
   logic [CMD_W-1:0]     rsp_command;
   logic [FREQ_W-1:0]    rsp_freq_word;
   logic [PHASE_W-1:0]   rsp_phase_word;
   logic                 rsp_hop_request;
   logic                 rsp_psk_request;
   logic                 rsp_rf_enable;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [FREQ_W-1:0]    csr_data = '0;

   // predictor copy of configuration and sequencer state
   logic [FREQ_W-1:0]    base_word   = '0;
   logic [FREQ_W-1:0]    offset_word = '0;
   logic [FREQ_W-1:0]    step_word   = '0;
   logic [HOP_CNT_W-1:0] hop_count_reg = 5'd1;
   logic [MSG_LEN_W-1:0] msg_len_reg   = 7'd1;
   mode_type             mode = MODE_IDLE;
   int unsigned          stage = 0;
   int unsigned          step_idx = 0;
   int unsigned          bit_idx = 0;
   logic [BYTE_W-1:0]    symbol_tab [MAX_HOPS];
   logic [BYTE_W-1:0]    message_tab [MAX_MESSAGE];
   bit                   last_took_effect;

   synth_cmd_type pending_commands[$];
   bit         steady_flow = 1'b0;
   int         stall_left = 0;
   int         cycles = 0;
   int         mismatch_count = 0;
   int         commands_checked = 0;
   int         items_sent = 0;
   int         effective_items = 0;
   int         hop_bursts = 0;
   int         psk_bursts = 0;
   int         config_phases = 0;

   beacon_hop_and_bpsk_sequencer #(
      .MAX_HOPS        (MAX_HOPS),
      .MAX_MESSAGE     (MAX_MESSAGE),
      .PREAMBLE_CLOCKS (PREAMBLE_CLOCKS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_slot        (req_slot),
      .req_load_value  (req_load_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_command     (rsp_command),
      .rsp_freq_word   (rsp_freq_word),
      .rsp_phase_word  (rsp_phase_word),
      .rsp_hop_request (rsp_hop_request),
      .rsp_psk_request (rsp_psk_request),
      .rsp_rf_enable   (rsp_rf_enable),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #4 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // response back-pressure: mostly short stalls, a few long ones
   always @(posedge clock) begin
      int r;
      r = $urandom_range(0, 99);
      if (reset || steady_flow) begin
         rsp_ready <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (r < 70) begin
         rsp_ready <= 1'b1;
      end else if (r < 95) begin
         stall_left <= $urandom_range(0, 2);
         rsp_ready <= 1'b0;
      end else begin
         stall_left <= $urandom_range(10, 30);
         rsp_ready <= 1'b0;
      end
   end

   function automatic int unsigned clamp_count(int unsigned v, int unsigned cap);
      if (v == 0) return 1;
      if (v > cap) return cap;
      return v;
   endfunction

   // common tail of both bursts: zero frequency, power down, release
   function automatic cmd_type wind_down(int unsigned first);
      if (stage == first) begin
         stage = first + 1;
         return CMD_FREQ;
      end
      if (stage == first + 1) begin
         stage = first + 2;
         return CMD_DOWN;
      end
      mode = MODE_IDLE;
      stage = 0;
      step_idx = 0;
      bit_idx = 0;
      return CMD_NONE;
   endfunction

   // advance the predicted sequencer by one transaction
   function automatic synth_cmd_type next_synth_command(logic [FUNC_W-1:0] func,
                                                        logic [SLOT_W-1:0] slot,
                                                        logic [BYTE_W-1:0] value);
      synth_cmd_type     c;
      logic [BYTE_W-1:0] b;
      c.command = CMD_NONE;
      c.freq_word = '0;
      c.phase_word = '0;
      last_took_effect = 1'b0;
      case (func)
         FUNC_HOP_TRIG, FUNC_PSK_TRIG: begin
            if (mode == MODE_IDLE) begin
               mode = (func == FUNC_HOP_TRIG) ? MODE_HOP : MODE_PSK;
               stage = 0;
               step_idx = 0;
               bit_idx = 0;
               c.command = CMD_UP;
               last_took_effect = 1'b1;
            end
         end
         FUNC_HOP_CLK: begin
            if (mode == MODE_HOP) begin
               last_took_effect = 1'b1;
               if (stage == HOP_TONE) begin
                  c.command = CMD_FREQ;
                  c.freq_word = base_word + offset_word + symbol_tab[step_idx] * step_word;
                  step_idx++;
                  if (step_idx >= clamp_count(hop_count_reg, MAX_HOPS)) begin
                     step_idx = 0;
                     stage = HOP_ZERO;
                  end
               end else begin
                  c.command = wind_down(HOP_ZERO);
               end
            end
         end
         FUNC_PSK_CLK: begin
            if (mode == MODE_PSK) begin
               last_took_effect = 1'b1;
               if (stage == PSK_CARRIER) begin
                  c.command = CMD_FREQ;
                  c.freq_word = base_word;
                  step_idx = 0;
                  stage = (PREAMBLE_CLOCKS > 1) ? PSK_PREAMBLE : PSK_BITS;
               end else if (stage == PSK_PREAMBLE) begin
                  step_idx++;
                  if (step_idx >= PREAMBLE_CLOCKS - 1) begin
                     step_idx = 0;
                     bit_idx = 0;
                     stage = PSK_BITS;
                  end
               end else if (stage == PSK_BITS) begin
                  // message bits go out LSB first
                  b = message_tab[step_idx];
                  c.command = CMD_PHASE;
                  c.phase_word = b[bit_idx] ? PHASE_ONE : '0;
                  bit_idx++;
                  if (bit_idx >= BYTE_W) begin
                     bit_idx = 0;
                     step_idx++;
                     if (step_idx >= clamp_count(msg_len_reg, MAX_MESSAGE)) begin
                        step_idx = 0;
                        stage = PSK_ZERO;
                     end
                  end
               end else begin
                  c.command = wind_down(PSK_ZERO);
               end
            end
         end
         FUNC_LOAD_SYM: begin
            if (slot < MAX_HOPS) begin
               symbol_tab[slot] = value;
               last_took_effect = 1'b1;
            end
         end
         FUNC_LOAD_MSG: begin
            if (slot < MAX_MESSAGE) begin
               message_tab[slot] = value;
               last_took_effect = 1'b1;
            end
         end
         default: ;
      endcase
      c.hop_req = (mode == MODE_HOP);
      c.psk_req = (mode == MODE_PSK);
      c.rf_en = (mode != MODE_IDLE);
      return c;
   endfunction

   function automatic bit check_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // response checker
   always @(posedge clock) begin
      synth_cmd_type exp_cmd;
      int            bad;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_commands.size() == 0) begin
            $error("response with no request outstanding: command 0x%0h", rsp_command);
            mismatch_count++;
         end else begin
            exp_cmd = pending_commands.pop_front();
            bad = 0;
            bad += check_field("command", exp_cmd.command, rsp_command);
            bad += check_field("freq_word", exp_cmd.freq_word, rsp_freq_word);
            bad += check_field("phase_word", exp_cmd.phase_word, rsp_phase_word);
            bad += check_field("hop_request", exp_cmd.hop_req, rsp_hop_request);
            bad += check_field("psk_request", exp_cmd.psk_req, rsp_psk_request);
            bad += check_field("rf_enable", exp_cmd.rf_en, rsp_rf_enable);
            if (bad != 0) mismatch_count++;
            commands_checked++;
         end
      end
   end

   // one request transaction; valid stays up after acceptance unless a gap follows
   task automatic send_item(logic [FUNC_W-1:0] func, logic [SLOT_W-1:0] slot,
                            logic [BYTE_W-1:0] value);
      int r;
      int gap;
      r = $urandom_range(0, 99);
      if (steady_flow || r < 50) gap = 0;
      else if (r < 85) gap = $urandom_range(1, 3);
      else if (r < 97) gap = $urandom_range(4, 10);
      else gap = $urandom_range(20, 40);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_slot <= slot;
      req_load_value <= value;
      do @(posedge clock); while (!req_ready);
      pending_commands.push_back(next_synth_command(func, slot, value));
      items_sent++;
      if (last_took_effect) effective_items++;
   endtask

   task automatic send_noise();
      send_item(FUNC_W'($urandom_range(0, 7)), SLOT_W'($urandom_range(0, 63)),
                BYTE_W'($urandom_range(0, 255)));
   endtask

   // stop sending and wait for every outstanding response
   task automatic drain();
      if (req_valid) req_valid <= 1'b0;
      while (pending_commands.size() != 0) @(posedge clock);
   endtask

   // register write; caller lowers csr_valid after its last write
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [FREQ_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_BASE_FREQ:      base_word = data;
         CSR_FREQ_OFFSET:    offset_word = data;
         CSR_HOP_SPACING:    step_word = data;
         CSR_HOP_COUNT:      hop_count_reg = data[HOP_CNT_W-1:0];
         CSR_MESSAGE_LENGTH: msg_len_reg = data[MSG_LEN_W-1:0];
         default: ;
      endcase
   endtask

   task automatic program_config(logic [FREQ_W-1:0] base, logic [FREQ_W-1:0] offset,
                                 logic [FREQ_W-1:0] step, logic [FREQ_W-1:0] hops,
                                 logic [FREQ_W-1:0] msg_len);
      write_reg(CSR_BASE_FREQ, base);
      write_reg(CSR_FREQ_OFFSET, offset);
      write_reg(CSR_HOP_SPACING, step);
      write_reg(CSR_HOP_COUNT, hops);
      write_reg(CSR_MESSAGE_LENGTH, msg_len);
      csr_valid <= 1'b0;
      config_phases++;
   endtask

   // trigger a burst and clock it to completion, with stray transactions mixed in;
   // earlier noise may already have started a burst, so clock whichever kind runs
   task automatic run_burst(bit psk, int noise_pct);
      send_item(psk ? FUNC_PSK_TRIG : FUNC_HOP_TRIG, '0, '0);
      if (mode == MODE_PSK) psk_bursts++;
      else hop_bursts++;
      while (mode != MODE_IDLE) begin
         if ($urandom_range(0, 99) < noise_pct) send_noise();
         else send_item((mode == MODE_PSK) ? FUNC_PSK_CLK : FUNC_HOP_CLK,
                        SLOT_W'($urandom_range(0, 63)), BYTE_W'($urandom_range(0, 255)));
      end
   endtask

   // both tables start undefined, so fill every entry before any burst reads one
   task automatic load_tables();
      for (int i = 0; i < MAX_HOPS; i++)
         send_item(FUNC_LOAD_SYM, SLOT_W'(i), BYTE_W'($urandom_range(0, 255)));
      for (int i = 0; i < MAX_MESSAGE; i++)
         send_item(FUNC_LOAD_MSG, SLOT_W'(i), BYTE_W'($urandom_range(0, 255)));
   endtask

   task automatic test_ignored_events();
      write_reg(CSR_SPARE, $urandom());
      csr_valid <= 1'b0;
      send_item(FUNC_HOP_CLK, '0, '0);
      send_item(FUNC_PSK_CLK, '0, '0);
      send_item(FUNC_UNUSED, 6'h3F, 8'hFF);
      send_item(FUNC_LOAD_SYM, 6'h3F, 8'hFF);
   endtask

   // all-ones words wrap the hop sum; hop count zero acts as one
   task automatic test_hop_extremes();
      drain();
      program_config('1, '1, '1, '0, 32'd1);
      send_item(FUNC_LOAD_SYM, '0, 8'hFF);
      send_item(FUNC_HOP_TRIG, '0, '0);
      send_item(FUNC_PSK_TRIG, '0, '0);
      send_item(FUNC_PSK_CLK, '0, '0);
      while (mode != MODE_IDLE) send_item(FUNC_HOP_CLK, '0, '0);
      hop_bursts++;
   endtask

   // message length zero acts as one; a byte loaded mid-burst is the one sent
   task automatic test_psk_minimal();
      drain();
      program_config(32'h0000_0001, '0, '0, 32'd16, '0);
      send_item(FUNC_PSK_TRIG, '0, '0);
      send_item(FUNC_PSK_CLK, '0, '0);
      send_item(FUNC_LOAD_MSG, '0, 8'hA5);
      while (mode != MODE_IDLE) send_item(FUNC_PSK_CLK, '0, '0);
      psk_bursts++;
   endtask

   function automatic logic [FREQ_W-1:0] pick_word();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return '0;
      if (r < 30) return '1;
      return $urandom();
   endfunction

   // config phases with bursts of random content; two phases use the longest message
   task automatic test_random_bursts();
      int          phase;
      int          target;
      int          r;
      int unsigned hops;
      int unsigned msg_len;
      logic [FREQ_W-1:0] upper;
      phase = 0;
      target = effective_items + RANDOM_WORK;
      while (effective_items < target) begin
         drain();
         r = $urandom_range(0, 99);
         if (r < 60) hops = $urandom_range(1, 16);
         else if (r < 80) hops = 16;
         else if (r < 90) hops = 0;
         else hops = $urandom_range(17, 31);
         r = $urandom_range(0, 99);
         if (phase == 2) msg_len = 64;
         else if (phase == 5) msg_len = $urandom_range(65, 127);
         else if (r < 75) msg_len = $urandom_range(1, 3);
         else if (r < 85) msg_len = 0;
         else msg_len = $urandom_range(4, 12);
         upper = ($urandom_range(0, 3) == 0) ? $urandom() : '0;
         program_config(pick_word(), pick_word(), pick_word(),
                        (upper << HOP_CNT_W) | hops, (upper << MSG_LEN_W) | msg_len);
         steady_flow = ($urandom_range(0, 4) == 0);
         if (phase == 2 || phase == 5) begin
            run_burst(1'b1, 10);
         end else begin
            repeat ($urandom_range(1, 4)) begin
               repeat ($urandom_range(0, 3)) send_noise();
               run_burst(1'($urandom_range(0, 1)), 12);
            end
         end
         steady_flow = 1'b0;
         phase++;
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_ignored_events();
      load_tables();
      test_hop_extremes();
      test_psk_minimal();
      test_random_bursts();
      drain();
      repeat (16) @(posedge clock);
      if (pending_commands.size() != 0) begin
         $error("%0d responses never arrived", pending_commands.size());
         mismatch_count++;
      end
      $display("Sent %0d requests over %0d register settings: %0d hop and %0d PSK bursts.",
               items_sent, config_phases, hop_bursts, psk_bursts);
      $display("Checked %0d responses, %0d with mismatches.", commands_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
